// ===== hw/rtl/bmns_pkg.sv =====
// ----------------------------------------------------------------------------
// bmns_pkg
// Shared types, constants and helpers of the Box-Muller normal sample unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bmns_pkg;

    // field widths
    localparam int U_W      = 16;
    localparam int Z_W      = 16;
    localparam int SAMPLE_W = 24;
    localparam int CFG_W    = 16;
    localparam int C_W      = 31;   // cos/sin value, Q30, at most 1.0
    localparam int S_W      = 19;   // sqrt(-2 ln u1) in Q16

    // fixed-point constants
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // register reset values, Q8.8
    localparam logic [CFG_W-1:0] MEAN_RESET = 16'd17920;
    localparam logic [CFG_W-1:0] STD_RESET  = 16'd5120;

    // register indexes
    typedef enum logic [0:0] {
        CFG_MEAN = 1'b0,
        CFG_STD  = 1'b1
    } t_cfg_idx;

    // Horner divisors, innermost first
    localparam int HORNER_N = 6;
    localparam int COS_DIV [HORNER_N] = '{132, 90, 56, 30, 12, 2};
    localparam int SIN_DIV [HORNER_N] = '{156, 110, 72, 42, 20, 6};

    // pipeline depths
    localparam int TRIG_LAT = 2 + 3 * HORNER_N + 1;
    localparam int RAD_LAT  = 1 + 24 + 1 + 1 + S_W;
    localparam int TOP_LAT  = RAD_LAT + 4;

    // angle unit result
    typedef struct packed {
        logic [C_W-1:0] cos_val;
        logic           neg;
    } t_trig;

    // radius unit result
    typedef struct packed {
        logic [S_W-1:0] root;
        logic           zero;
    } t_rad;

    // log2 in Q4.24 by repeated squaring, used for constants only
    function automatic logic [27:0] log2_q24(input logic [15:0] x);
        logic [3:0]  e;
        logic [63:0] m;
        logic [23:0] frac;
        e    = 4'd0;
        frac = 24'd0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) begin
                e = 4'(i);
            end
        end
        m = {48'd0, x} << (6'd31 - {2'b00, e});
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 31;
            if (m[32]) begin
                frac[23-i] = 1'b1;
                m = m >> 1;
            end
        end
        return {e, frac};
    endfunction

    localparam logic [27:0] LOG2_MAX = log2_q24(16'hFFFF);

endpackage

`default_nettype wire

// ===== hw/rtl/bmns_sincos.sv =====
// ----------------------------------------------------------------------------
// bmns_sincos
// Pipelined angle unit: phase from the second code, then the quadrant
// cosine or sine from Taylor Horner forms in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module bmns_sincos (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [bmns_pkg::U_W-1:0] i_u,
    output bmns_pkg::t_trig              o_trig
);

    localparam int N  = bmns_pkg::HORNER_N;
    localparam int LX = 2 + 3 * N;   // number of side delay stages; the last has index LX-1

    logic [30:0] r_xd  [0:LX-1];
    logic [1:0]  r_qd  [0:LX-1];
    logic [31:0] r_x2d [1:3*N-2];
    logic [31:0] r_v   [0:N-1];
    logic [31:0] r_q   [0:N-1];
    logic [30:0] r_t   [0:N-1];
    logic [30:0] r_c;
    logic        r_neg;

    // phase in turns, a full code wraps to zero
    logic [31:0] w_phase;
    logic [60:0] w_xprod;
    logic [61:0] w_x2prod;
    assign w_phase  = (i_u == 16'hFFFF) ? 32'd0 : {i_u, i_u};
    assign w_xprod  = 61'(w_phase[29:0]) * 61'(bmns_pkg::HALF_PI_Q30);
    assign w_x2prod = 62'(r_xd[0]) * 62'(r_xd[0]);

    // angle and its square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xd[0]  <= w_xprod[60:30];
            r_qd[0]  <= w_phase[31:30];
            r_x2d[1] <= w_x2prod[61:30];
        end
    end

    // side delay lines for angle and quadrant
    for (genvar k = 1; k < LX; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xd[k] <= r_xd[k-1];
                r_qd[k] <= r_qd[k-1];
            end
        end
    end

    for (genvar k = 2; k <= 3 * N - 2; k++) begin : g_x2d
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x2d[k] <= r_x2d[k-1];
            end
        end
    end

    // Horner steps: product, reciprocal divide, one minus
    for (genvar i = 0; i < N; i++) begin : g_horner
        localparam int KC = bmns_pkg::COS_DIV[i];
        localparam int KS = bmns_pkg::SIN_DIV[i];
        localparam int LC = $clog2(KC);
        localparam int LS = $clog2(KS);
        localparam logic [64:0] MC_W = ((65'd1 << (32 + LC)) + 65'(KC) - 65'd1) / 65'(KC);
        localparam logic [64:0] MS_W = ((65'd1 << (32 + LS)) + 65'(KS) - 65'd1) / 65'(KS);
        localparam logic [32:0] MC = MC_W[32:0];
        localparam logic [32:0] MS = MS_W[32:0];

        logic [30:0] w_tin;
        logic [62:0] w_vprod;
        logic        w_sin;
        logic [32:0] w_m;
        logic [6:0]  w_sh;
        logic [64:0] w_wprod;
        logic [64:0] w_qfull;

        if (i == 0) begin : g_first
            assign w_tin = bmns_pkg::Q30_ONE;
        end else begin : g_next
            assign w_tin = r_t[i-1];
        end

        assign w_vprod = 63'(r_x2d[1+3*i]) * 63'(w_tin);
        assign w_sin   = r_qd[2+3*i][0];
        assign w_m     = w_sin ? MS : MC;
        assign w_sh    = w_sin ? 7'(32 + LS) : 7'(32 + LC);
        assign w_wprod = 65'(r_v[i]) * 65'(w_m);
        assign w_qfull = w_wprod >> w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[i] <= w_vprod[61:30];
                r_q[i] <= w_qfull[31:0];
                r_t[i] <= (r_q[i] >= 32'(bmns_pkg::Q30_ONE)) ? 31'd0
                        : 31'(32'(bmns_pkg::Q30_ONE) - r_q[i]);
            end
        end
    end

    // sine takes one more product with the angle
    logic [61:0] w_sprod;
    assign w_sprod = 62'(r_xd[LX-1]) * 62'(r_t[N-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c   <= r_qd[LX-1][0] ? w_sprod[60:30] : r_t[N-1];
            r_neg <= r_qd[LX-1][0] ^ r_qd[LX-1][1];
        end
    end

    assign o_trig.cos_val = r_c;
    assign o_trig.neg     = r_neg;

endmodule

`default_nettype wire

// ===== hw/rtl/bmns_radius.sv =====
// ----------------------------------------------------------------------------
// bmns_radius
// Pipelined radius unit: log2 by one squaring per stage, scaling to
// -2 ln u1, then a bit-serial square root with one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bmns_radius (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [bmns_pkg::U_W-1:0] i_u,
    output bmns_pkg::t_rad               o_rad
);

    localparam int NSQ = 24;
    localparam int NRT = bmns_pkg::S_W;
    localparam int LAT = bmns_pkg::RAD_LAT;

    logic [31:0] r_m    [0:NSQ];
    logic [23:0] r_frac [0:NSQ];
    logic [3:0]  r_e    [0:NSQ];
    logic [27:0] r_d;
    logic [28:0] r_l;
    logic [37:0] r_sn   [0:NRT-1];
    logic [37:0] r_sr   [0:NRT-1];
    logic        r_zero [0:LAT-1];

    // normalize the code so its top bit lands on bit 31
    logic [3:0]  w_e;
    logic [46:0] w_sh;
    always_comb begin
        w_e = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (i_u[i]) begin
                w_e = 4'(i);
            end
        end
    end
    assign w_sh = {31'd0, i_u} << (5'd31 - {1'b0, w_e});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]    <= w_sh[31:0];
            r_e[0]    <= w_e;
            r_frac[0] <= 24'd0;
            r_zero[0] <= (i_u == 16'd0);
        end
    end

    // zero-code flag travels alongside
    for (genvar k = 1; k < LAT; k++) begin : g_zero
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // one fraction bit per squaring
    for (genvar j = 1; j <= NSQ; j++) begin : g_sq
        logic [63:0] w_p;
        logic [32:0] w_s;
        logic [23:0] w_f;
        assign w_p = 64'(r_m[j-1]) * 64'(r_m[j-1]);
        assign w_s = w_p[63:31];
        always_comb begin
            w_f           = r_frac[j-1];
            w_f[NSQ - j]  = w_s[32];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]    <= w_s[32] ? w_s[32:1] : w_s[31:0];
                r_frac[j] <= w_f;
                r_e[j]    <= r_e[j-1];
            end
        end
    end

    // d = log2(max) - log2(u1), then L = d * 2 ln 2 rounded to Q24
    logic [27:0] w_lb;
    logic [58:0] w_lp;
    logic [59:0] w_lr;
    assign w_lb = {r_e[NSQ], r_frac[NSQ]};
    assign w_lp = 59'(r_d) * 59'(bmns_pkg::TWO_LN2_Q30);
    assign w_lr = 60'(w_lp) + (60'd1 << 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= (bmns_pkg::LOG2_MAX > w_lb) ? (bmns_pkg::LOG2_MAX - w_lb) : 28'd0;
            r_l <= w_lr[58:30];
        end
    end

    // square root of L * 2^8, one result bit per stage
    for (genvar j = 0; j < NRT; j++) begin : g_rt
        localparam logic [37:0] BIT = 38'd1 << (36 - 2 * j);
        logic [37:0] w_n;
        logic [37:0] w_r;
        logic [37:0] w_t;
        if (j == 0) begin : g_first
            assign w_n = {1'b0, r_l, 8'd0};
            assign w_r = 38'd0;
        end else begin : g_next
            assign w_n = r_sn[j-1];
            assign w_r = r_sr[j-1];
        end
        assign w_t = w_r + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_n >= w_t) begin
                    r_sn[j] <= w_n - w_t;
                    r_sr[j] <= (w_r >> 1) + BIT;
                end else begin
                    r_sn[j] <= w_n;
                    r_sr[j] <= w_r >> 1;
                end
            end
        end
    end

    assign o_rad.root = r_sr[NRT-1][NRT-1:0];
    assign o_rad.zero = r_zero[LAT-1];

endmodule

`default_nettype wire

// ===== hw/rtl/box_muller_normal_sample_unit.sv =====
// ----------------------------------------------------------------------------
// box_muller_normal_sample_unit
// Box-Muller normal sample generator: Z = sqrt(-2 ln u1) cos(2 pi u2) in
// Q4.12 and the scaled sample std_dev * Z + mean in Q15.8.
// ----------------------------------------------------------------------------
// depth: the 46-stage log and square root chain sets the length of the pipeline
// throughput: one transaction per cycle; the whole pipeline holds while a
//   result waits on the output
// reset: synchronous, active low; clears all valid bits and loads the
//   mean and std_dev registers with 70.0 and 20.0
`default_nettype none

module box_muller_normal_sample_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // u_first[15:0], u_second[31:16]
    // output stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,   // normal_z[15:0], sample_value[39:16]
    output logic [0:0]       o_m_axis_tuser    // log_zero_flag[0]
);

    localparam int LAT  = bmns_pkg::TOP_LAT;
    localparam int RLAT = bmns_pkg::RAD_LAT;
    localparam int DLY  = bmns_pkg::RAD_LAT - bmns_pkg::TRIG_LAT;

    logic [15:0]     r_mean;
    logic [15:0]     r_std;
    logic            r_vld [0:LAT-1];
    logic            w_adv;
    bmns_pkg::t_trig w_trig;
    bmns_pkg::t_rad  w_rad;
    bmns_pkg::t_trig r_tdly [0:DLY-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= bmns_pkg::MEAN_RESET;
            r_std  <= bmns_pkg::STD_RESET;
        end else if (i_cfg_we) begin
            case (bmns_pkg::t_cfg_idx'(i_cfg_index))
                bmns_pkg::CFG_MEAN: r_mean <= i_cfg_data;
                bmns_pkg::CFG_STD:  r_std  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result waits on the output
    assign w_adv           = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
    end

    for (genvar k = 1; k < LAT; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // the two arms of the transform
    bmns_radius u_radius (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_u   (i_s_axis_tdata[15:0]),
        .o_rad (w_rad)
    );

    bmns_sincos u_sincos (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_u    (i_s_axis_tdata[31:16]),
        .o_trig (w_trig)
    );

    // align the angle arm with the longer radius arm
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdly[0] <= w_trig;
        end
    end

    for (genvar k = 1; k < DLY; k++) begin : g_tdly
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_tdly[k] <= r_tdly[k-1];
            end
        end
    end

    // |Z| = (S * c + 2^33) >> 34
    logic [49:0] w_zp;
    logic [50:0] w_zr;
    logic [16:0] r_zmag;
    logic        r_neg1;
    logic        r_zero1;
    assign w_zp = 50'(w_rad.root) * 50'(r_tdly[DLY-1].cos_val);
    assign w_zr = 51'(w_zp) + (51'd1 << 33);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zmag  <= w_zr[50:34];
            r_neg1  <= r_tdly[DLY-1].neg;
            r_zero1 <= w_rad.zero;
        end
    end

    // saturate, apply sign, zero-code override
    logic [15:0] w_zsat;
    logic [15:0] r_z2;
    logic        r_flag2;
    assign w_zsat = (r_zmag > 17'd32767) ? 16'd32767 : r_zmag[15:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_zero1) begin
                r_z2 <= r_neg1 ? 16'h8000 : 16'h7FFF;
            end else begin
                r_z2 <= r_neg1 ? (16'd0 - w_zsat) : w_zsat;
            end
            r_flag2 <= r_zero1;
        end
    end

    // std_dev * Z
    logic signed [32:0] r_prod3;
    logic [15:0]        r_z3;
    logic               r_flag3;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod3 <= 33'(signed'({1'b0, r_std}) * signed'(r_z2));
            r_z3    <= r_z2;
            r_flag3 <= r_flag2;
        end
    end

    // round half away from zero, add mean
    logic [32:0] w_pmag;
    logic [32:0] w_pr;
    logic [23:0] w_rnd;
    logic [23:0] w_sample;
    logic [15:0] r_oz;
    logic [23:0] r_osample;
    logic        r_oflag;
    assign w_pmag   = r_prod3[32] ? (33'd0 - r_prod3) : r_prod3;
    assign w_pr     = (w_pmag + 33'd2048) >> 12;
    assign w_rnd    = r_prod3[32] ? (24'd0 - w_pr[23:0]) : w_pr[23:0];
    assign w_sample = w_rnd + {8'd0, r_mean};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oz      <= r_z3;
            r_osample <= w_sample;
            r_oflag   <= r_flag3;
        end
    end

    assign o_m_axis_tvalid = r_vld[LAT-1];
    assign o_m_axis_tdata  = {r_osample, r_oz};
    assign o_m_axis_tuser  = r_oflag;

endmodule

`default_nettype wire

// ===== hw/rtl/bmns_checker.sv =====
// ----------------------------------------------------------------------------
// bmns_checker
// Port-level checks of the Box-Muller normal sample unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bmns_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic [0:0]  o_m_axis_tuser
);

    // no result appears right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // an empty output never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // a zero first code gives a saturated Z
    a_flag_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (o_m_axis_tdata[15:0] == 16'h7FFF || o_m_axis_tdata[15:0] == 16'h8000))
        else $error("log zero flag without saturated Z");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind box_muller_normal_sample_unit bmns_checker u_bmns_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
